// ===== sv/pntp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pntp_pkg;

    // Width of a number base (covers 0..63)
    localparam int unsigned BASE_W = 6;

    // Prefix characters
    localparam logic [7:0] CHAR_HEX   = 8'h24;   // '$'
    localparam logic [7:0] CHAR_BIN   = 8'h25;   // '%'
    localparam logic [7:0] CHAR_DEC   = 8'h23;   // '#'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;   // '-'

    // Bases selected by the prefixes, and the reset base
    localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
    localparam logic [BASE_W-1:0] BASE_BIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_DEC   = 6'd10;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

    // Per-token control flags
    typedef struct packed {
        logic negative;
        logic at_first;
        logic bad_digit;
    } tok_flags_t;

    localparam tok_flags_t FLAGS_CLEAR = '{negative: 1'b0, at_first: 1'b1, bad_digit: 1'b0};

endpackage

`default_nettype wire

// ===== sv/pntp_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next-state and result logic for one character of a token.
module pntp_step #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic [7:0]                  character,
    input  wire logic                        last_char,
    input  wire logic [pntp_pkg::BASE_W-1:0] default_base,
    input  wire logic [VALUE_BITS-1:0]       acc,
    input  wire logic [pntp_pkg::BASE_W-1:0] base,
    input  wire pntp_pkg::tok_flags_t        flags,
    output logic [VALUE_BITS-1:0]            acc_next,
    output logic [pntp_pkg::BASE_W-1:0]      base_next,
    output pntp_pkg::tok_flags_t             flags_next,
    output logic                             res_is_number,
    output logic [31:0]                      res_value
);

    logic                        is_digit_char;
    logic [pntp_pkg::BASE_W-1:0] digit;
    logic [pntp_pkg::BASE_W-1:0] eff_base;
    logic                        is_prefix;
    logic                        take;
    logic                        digit_ok;
    logic [VALUE_BITS-1:0]       prod;
    logic [VALUE_BITS-1:0]       acc_upd;
    logic                        bad_upd;
    logic                        neg_upd;
    logic [VALUE_BITS-1:0]       signed_val;

    // Decode the character into a digit value, case-insensitive
    always_comb
    begin
        is_digit_char = 1'b0;
        digit         = '0;
        if (character >= 8'h30 && character <= 8'h39)
        begin
            is_digit_char = 1'b1;
            digit         = pntp_pkg::BASE_W'(character - 8'h30);
        end
        else if (character >= 8'h61 && character <= 8'h7A)
        begin
            is_digit_char = 1'b1;
            digit         = pntp_pkg::BASE_W'(character - 8'h57);
        end
        else if (character >= 8'h41 && character <= 8'h5A)
        begin
            is_digit_char = 1'b1;
            digit         = pntp_pkg::BASE_W'(character - 8'h37);
        end
    end

    // Pick the base and detect a prefix on the first character
    always_comb
    begin
        eff_base  = flags.at_first ? default_base : base;
        is_prefix = 1'b0;
        neg_upd   = flags.negative;
        if (flags.at_first)
        begin
            unique case (character)
                pntp_pkg::CHAR_HEX:
                begin
                    eff_base  = pntp_pkg::BASE_HEX;
                    is_prefix = 1'b1;
                end
                pntp_pkg::CHAR_BIN:
                begin
                    eff_base  = pntp_pkg::BASE_BIN;
                    is_prefix = 1'b1;
                end
                pntp_pkg::CHAR_DEC:
                begin
                    eff_base  = pntp_pkg::BASE_DEC;
                    is_prefix = 1'b1;
                end
                pntp_pkg::CHAR_MINUS:
                begin
                    is_prefix = 1'b1;
                    neg_upd   = 1'b1;
                end
                default:
                begin
                    is_prefix = 1'b0;
                end
            endcase
        end
    end

    // Multiply-add one digit into the accumulator
    assign take     = !is_prefix && !flags.bad_digit;
    assign digit_ok = is_digit_char && (digit < eff_base);
    assign prod     = acc * {{(VALUE_BITS-pntp_pkg::BASE_W){1'b0}}, eff_base};

    always_comb
    begin
        acc_upd = acc;
        bad_upd = flags.bad_digit;
        if (take)
        begin
            if (digit_ok)
                acc_upd = prod + {{(VALUE_BITS-pntp_pkg::BASE_W){1'b0}}, digit};
            else
                bad_upd = 1'b1;
        end
    end

    // Finish the token on its last character
    assign signed_val    = neg_upd ? (~acc_upd + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : acc_upd;
    assign res_is_number = !bad_upd;

    generate
        if (VALUE_BITS >= 32)
        begin : g_trunc
            assign res_value = bad_upd ? 32'd0 : signed_val[31:0];
        end
        else
        begin : g_ext
            assign res_value = bad_upd ? 32'd0 : {{(32-VALUE_BITS){1'b0}}, signed_val};
        end
    endgenerate

    // Clear the token state after the last character
    always_comb
    begin
        if (last_char)
        begin
            acc_next   = '0;
            base_next  = default_base;
            flags_next = pntp_pkg::FLAGS_CLEAR;
        end
        else
        begin
            acc_next   = acc_upd;
            base_next  = eff_base;
            flags_next = '{negative: neg_upd, at_first: 1'b0, bad_digit: bad_upd};
        end
    end

endmodule

`default_nettype wire

// ===== sv/prefixed_number_token_parser_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Prefixed number token parser. Characters of a token arrive one item per
// cycle on the slave stream unless stalled, with tlast on the final
// character. A leading '$', '%' or '#' selects base 16, 2 or 10 and a
// leading '-' negates the result; otherwise the base written through
// cfg_wr_data (reset 10) applies, sampled at the first character of each
// token. Each last character yields one result item: tuser is 1 when every
// character after any prefix is a digit of the base, tdata carries the
// value in 32-bit two's complement (zero when invalid). The multiply-add by
// the base sits between the token state registers and the result register,
// so a result appears in the cycle after its last character is accepted.
// Input stalls only while a result waits and the master side holds tready low.
module prefixed_number_token_parser_top #(
    parameter int unsigned VALUE_BITS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: default base
    input  wire logic        cfg_wr_en,
    input  wire logic [5:0]  cfg_wr_data,
    // character stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] character
    input  wire logic        s_axis_tlast,   // last_char
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] value
    output logic [0:0]       m_axis_tuser    // [0] is_number
);

    logic [pntp_pkg::BASE_W-1:0] default_base_reg;
    logic [VALUE_BITS-1:0]       acc_reg;
    logic [VALUE_BITS-1:0]       acc_next;
    logic [pntp_pkg::BASE_W-1:0] base_reg;
    logic [pntp_pkg::BASE_W-1:0] base_next;
    pntp_pkg::tok_flags_t        flags_reg;
    pntp_pkg::tok_flags_t        flags_next;
    logic                        res_is_number;
    logic [31:0]                 res_value;
    logic                        out_valid_reg;
    logic                        out_is_number_reg;
    logic [31:0]                 out_value_reg;
    logic                        in_fire;

    // Accept unless a result is waiting and stalled
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Hold the default base
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            default_base_reg <= pntp_pkg::BASE_RESET;
        else if (cfg_wr_en)
            default_base_reg <= cfg_wr_data;
    end

    pntp_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_step (
        .character     (s_axis_tdata),
        .last_char     (s_axis_tlast),
        .default_base  (default_base_reg),
        .acc           (acc_reg),
        .base          (base_reg),
        .flags         (flags_reg),
        .acc_next      (acc_next),
        .base_next     (base_next),
        .flags_next    (flags_next),
        .res_is_number (res_is_number),
        .res_value     (res_value)
    );

    // Advance the token state on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            base_reg  <= pntp_pkg::BASE_RESET;
            flags_reg <= pntp_pkg::FLAGS_CLEAR;
        end
        else if (in_fire)
        begin
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            flags_reg <= flags_next;
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire && s_axis_tlast)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (in_fire && s_axis_tlast)
        begin
            out_is_number_reg <= res_is_number;
            out_value_reg     <= res_value;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_value_reg;
    assign m_axis_tuser[0] = out_is_number_reg;

`ifndef SYNTH
    a_rise_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(in_fire && s_axis_tlast))
        else $error("result appeared without an accepted last character");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == 32'd0))
        else $error("invalid token carries a nonzero value");

    a_token_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_axis_tlast) |=>
            (flags_reg.at_first && !flags_reg.bad_digit && !flags_reg.negative
             && acc_reg == '0))
        else $error("token state not cleared after last character");
`endif

endmodule

`default_nettype wire
